// ===== rtl/greedy_stream_bipartite_matcher_macros.svh =====
// ---------------------------------------------------------------------------
// Greedy stream bipartite matcher assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GREEDY_STREAM_BIPARTITE_MATCHER_MACROS_SVH
`define GREEDY_STREAM_BIPARTITE_MATCHER_MACROS_SVH

// same-cycle implication
`define GSBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GSBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gsbm_pkg.sv =====
// ---------------------------------------------------------------------------
// Greedy stream bipartite matcher package
// Shared types and command codes.
// ---------------------------------------------------------------------------
package gsbm_pkg;

  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } map_ctl_t;

endpackage

// ===== rtl/greedy_stream_bipartite_matcher.sv =====
// ---------------------------------------------------------------------------
// Greedy stream bipartite matcher
// Streams weighted edges grouped by producer, emits one greedy match
// decision per item, with a matched-node map held in block memory.
// ---------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tuser: command; tdata: first_node, second_node, edge_weight
//  m_axis   | out       | tuser: match_valid; tdata: match fields, totals, in_order
//  cfg      | in        | cfg_data: swap_ends
//
// One item per cycle sustained while m_axis_tready is high and the map is not clearing;
// an accepted item is registered in the map stage and then in the output register before
// m_axis. The map read is issued at accept and used in the map stage; a mark written on that same edge is forwarded.
// After reset the map is cleared one entry a cycle, all 2**NODE_BITS entries,
// with s_axis_tready low. cfg writes are always taken.
// A stalled m_axis holds one result; one more item waits in the map stage.
`include "greedy_stream_bipartite_matcher_macros.svh"

module greedy_stream_bipartite_matcher import gsbm_pkg::*; #(
  parameter int NODE_BITS   = 16,
  parameter int WEIGHT_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic s_axis_tuser,   // command
  // first_node, second_node, edge_weight
  input  logic [((2*NODE_BITS+WEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic m_axis_tuser,   // match_valid
  // matched_producer, matched_consumer, matched_weight, total_weight,
  // match_count, in_order
  output logic [((3*NODE_BITS+2*WEIGHT_BITS+18+7)/8)*8-1:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data        // swap_ends
);

  localparam int SUM_BITS = WEIGHT_BITS + 16;
  localparam int CNT_BITS = NODE_BITS + 1;
  localparam int OUT_RAW  = 3*NODE_BITS + 2*WEIGHT_BITS + 18;

  logic                   swap;
  logic                   accept;
  logic                   busy;
  logic [NODE_BITS-1:0]   in_p;
  logic [NODE_BITS-1:0]   in_c;
  logic [WEIGHT_BITS-1:0] in_w;

  logic                   b_valid;
  logic                   b_cmd;
  logic [NODE_BITS-1:0]   b_p;
  logic [NODE_BITS-1:0]   b_c;
  logic [WEIGHT_BITS-1:0] b_w;
  logic                   b_fwd;
  logic                   b_adv;

  map_ctl_t               map_ctl;
  logic                   rd_hit;
  logic                   hit;
  logic                   fwd_now;
  logic [NODE_BITS-1:0]   mark_prod;
  logic [NODE_BITS-1:0]   mark_cons;
  logic [NODE_BITS-1:0]   res_prod;
  logic [NODE_BITS-1:0]   res_cons;
  logic [WEIGHT_BITS-1:0] res_wt;
  logic [SUM_BITS-1:0]    res_sum;
  logic [CNT_BITS-1:0]    res_cnt;
  logic                   res_order;

  logic                   out_valid;
  logic                   out_match;
  logic [NODE_BITS-1:0]   out_prod;
  logic [NODE_BITS-1:0]   out_cons;
  logic [WEIGHT_BITS-1:0] out_wt;
  logic [SUM_BITS-1:0]    out_sum;
  logic [CNT_BITS-1:0]    out_cnt;
  logic                   out_order;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap <= 1'b0;
    end else if (cfg_valid) begin
      swap <= cfg_data;
    end
  end

  always_comb begin
    in_w = s_axis_tdata[2*NODE_BITS+WEIGHT_BITS-1:2*NODE_BITS];
    if (swap) begin
      in_p = s_axis_tdata[2*NODE_BITS-1:NODE_BITS];
      in_c = s_axis_tdata[NODE_BITS-1:0];
    end else begin
      in_p = s_axis_tdata[NODE_BITS-1:0];
      in_c = s_axis_tdata[2*NODE_BITS-1:NODE_BITS];
    end
    b_adv         = b_valid && (!out_valid || m_axis_tready);
    s_axis_tready = !busy && (!b_valid || b_adv);
    accept        = s_axis_tvalid && s_axis_tready;
    fwd_now       = b_adv && hit && ((in_c == mark_prod) || (in_c == mark_cons));
    map_ctl.rd_en = accept;
    map_ctl.wr_en = b_adv && hit;
  end

  gsbm_map #(
    .NODE_BITS(NODE_BITS)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .ctl     (map_ctl),
    .rd_addr (in_c),
    .wr_prod (mark_prod),
    .wr_cons (mark_cons),
    .rd_hit  (rd_hit),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_cmd <= s_axis_tuser;
      b_p   <= in_p;
      b_c   <= in_c;
      b_w   <= in_w;
      b_fwd <= fwd_now;
    end
  end

  gsbm_group #(
    .NODE_BITS  (NODE_BITS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_group (
    .clk        (clk),
    .rst        (rst),
    .adv        (b_adv),
    .cmd        (b_cmd),
    .p          (b_p),
    .c          (b_c),
    .w          (b_w),
    .mem_marked (rd_hit || b_fwd),
    .hit        (hit),
    .mark_prod  (mark_prod),
    .mark_cons  (mark_cons),
    .res_prod   (res_prod),
    .res_cons   (res_cons),
    .res_wt     (res_wt),
    .res_sum    (res_sum),
    .res_cnt    (res_cnt),
    .res_order  (res_order)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_match <= hit;
      out_prod  <= res_prod;
      out_cons  <= res_cons;
      out_wt    <= res_wt;
      out_sum   <= res_sum;
      out_cnt   <= res_cnt;
      out_order <= res_order;
    end
  end

  always_comb begin
    m_axis_tvalid = out_valid;
    m_axis_tuser  = out_match;
    m_axis_tdata  = '0;
    m_axis_tdata[OUT_RAW-1:0] = {out_order, out_cnt, out_sum, out_wt, out_cons, out_prod};
  end

  `GSBM_ASSERT_NOW(a_match_counted, out_valid && out_match, out_cnt != '0, "match with zero count")

endmodule

// ===== rtl/gsbm_map.sv =====
// ---------------------------------------------------------------------------
// Matched node map
// Two 1-bit memories (producer marks, consumer marks), one write and one
// registered read each per cycle, with a clearing pass after reset.
// ---------------------------------------------------------------------------
`include "greedy_stream_bipartite_matcher_macros.svh"

module gsbm_map import gsbm_pkg::*; #(
  parameter int NODE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  map_ctl_t             ctl,
  input  logic [NODE_BITS-1:0] rd_addr,
  input  logic [NODE_BITS-1:0] wr_prod,
  input  logic [NODE_BITS-1:0] wr_cons,
  output logic                 rd_hit,
  output logic                 busy
);

  localparam int DEPTH = 1 << NODE_BITS;

  logic                 prod_mem [DEPTH];
  logic                 cons_mem [DEPTH];
  logic                 prod_rd;
  logic                 cons_rd;
  logic [NODE_BITS-1:0] clr_addr;
  logic                 prod_we;
  logic                 cons_we;
  logic [NODE_BITS-1:0] prod_wa;
  logic [NODE_BITS-1:0] cons_wa;
  logic                 wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + NODE_BITS'(1);
      if (clr_addr == '1) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    prod_we = busy || ctl.wr_en;
    cons_we = busy || ctl.wr_en;
    prod_wa = busy ? clr_addr : wr_prod;
    cons_wa = busy ? clr_addr : wr_cons;
    wd      = !busy;
  end

  always_ff @(posedge clk) begin
    if (prod_we) begin
      prod_mem[prod_wa] <= wd;
    end
    if (ctl.rd_en) begin
      prod_rd <= prod_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cons_we) begin
      cons_mem[cons_wa] <= wd;
    end
    if (ctl.rd_en) begin
      cons_rd <= cons_mem[rd_addr];
    end
  end

  assign rd_hit = prod_rd | cons_rd;

  `GSBM_ASSERT_NOW(a_no_access_in_clear, busy, !ctl.wr_en && !ctl.rd_en, "map accessed during clear")

endmodule

// ===== rtl/gsbm_group.sv =====
// ---------------------------------------------------------------------------
// Group tracker
// Running maximum of the open producer group, group close, match totals.
// ---------------------------------------------------------------------------
`include "greedy_stream_bipartite_matcher_macros.svh"

module gsbm_group import gsbm_pkg::*; #(
  parameter int NODE_BITS   = 16,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     cmd,
  input  logic [NODE_BITS-1:0]     p,
  input  logic [NODE_BITS-1:0]     c,
  input  logic [WEIGHT_BITS-1:0]   w,
  input  logic                     mem_marked,
  output logic                     hit,
  output logic [NODE_BITS-1:0]     mark_prod,
  output logic [NODE_BITS-1:0]     mark_cons,
  output logic [NODE_BITS-1:0]     res_prod,
  output logic [NODE_BITS-1:0]     res_cons,
  output logic [WEIGHT_BITS-1:0]   res_wt,
  output logic [WEIGHT_BITS+15:0]  res_sum,
  output logic [NODE_BITS:0]       res_cnt,
  output logic                     res_order
);

  localparam int SUM_BITS = WEIGHT_BITS + 16;
  localparam int CNT_BITS = NODE_BITS + 1;

  logic [NODE_BITS-1:0]   gp, gp_next;
  logic [NODE_BITS-1:0]   bc, bc_next;
  logic [WEIGHT_BITS-1:0] bw, bw_next;
  logic                   open, open_next;
  logic [SUM_BITS-1:0]    sum, sum_next;
  logic [CNT_BITS-1:0]    cnt, cnt_next;
  logic                   order, order_next;

  logic                   finish;
  logic                   close_req;
  logic                   backward;
  logic                   marked;
  logic                   fold;
  logic [WEIGHT_BITS-1:0] base_bw;
  logic [SUM_BITS:0]      sum_ext;

  always_comb begin
    finish    = (cmd == CMD_FINISH);
    close_req = finish || (p > gp);
    backward  = !finish && (p < gp);
    hit       = close_req && open && (gp != '0) && (bc != '0) && (bw != '0);
    // marks made by this close are visible to this edge
    marked    = mem_marked || (hit && ((c == gp) || (c == bc)));
    fold      = !finish && !backward;
    base_bw   = close_req ? '0 : bw;

    gp_next    = (close_req && !finish) ? p : gp;
    bc_next    = close_req ? '0 : bc;
    bw_next    = base_bw;
    open_next  = close_req ? 1'b0 : open;
    order_next = backward ? 1'b0 : order;
    if (fold) begin
      open_next = 1'b1;
      if (!marked && (base_bw < w)) begin
        bw_next = w;
        bc_next = c;
      end
    end

    sum_ext  = {1'b0, sum} + (SUM_BITS+1)'(bw);
    sum_next = sum;
    cnt_next = cnt;
    if (hit) begin
      sum_next = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
      if (cnt != '1) begin
        cnt_next = cnt + CNT_BITS'(1);
      end
    end

    mark_prod = gp;
    mark_cons = bc;
    res_prod  = hit ? gp : '0;
    res_cons  = hit ? bc : '0;
    res_wt    = hit ? bw : '0;
    res_sum   = sum_next;
    res_cnt   = cnt_next;
    res_order = order_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gp    <= '0;
      bc    <= '0;
      bw    <= '0;
      open  <= 1'b0;
      sum   <= '0;
      cnt   <= '0;
      order <= 1'b1;
    end else if (adv) begin
      gp    <= gp_next;
      bc    <= bc_next;
      bw    <= bw_next;
      open  <= open_next;
      sum   <= sum_next;
      cnt   <= cnt_next;
      order <= order_next;
    end
  end

  `GSBM_ASSERT_NEXT(a_order_sticky, !order, !order, "in-order flag came back")

endmodule
